>>> hdl/rzs_pkg.sv
package rzs_pkg;

  // fixed datapath widths, set by the field widths and a count of at most 127
  localparam int unsigned SumW  = 24;  // running sum, signed
  localparam int unsigned SqW   = 38;  // running sum of squares
  localparam int unsigned DevW  = 46;  // n*Q - S*S
  localparam int unsigned NumW  = 24;  // n*s - S, signed
  localparam int unsigned OpW   = 64;  // left-aligned operand of the shared unit
  localparam int unsigned RemW  = 47;  // partial remainder of the shared unit
  localparam int unsigned StepW = 7;

  // register indexes
  localparam logic [2:0] RegWindowLength = 3'd0;
  localparam logic [2:0] RegMinCount     = 3'd1;
  localparam logic [2:0] RegSoftLimit    = 3'd2;
  localparam logic [2:0] RegHardLimit    = 3'd3;

  // request kinds
  localparam logic ReqSample = 1'b0;
  localparam logic ReqClear  = 1'b1;

  // severity grades
  localparam logic [1:0] SevNone = 2'd0;
  localparam logic [1:0] SevSoft = 2'd1;
  localparam logic [1:0] SevHard = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] sample_value;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] z_score;
    logic               z_valid;
    logic [1:0]         severity;
    logic signed [15:0] window_mean;
    logic [15:0]        window_stddev;
    logic [6:0]         fill_level;
    logic [31:0]        total_samples;
    logic [31:0]        soft_events;
    logic [31:0]        hard_events;
  } out_res_t;

  // command to the shared divide / square root unit
  typedef struct packed {
    logic             start;
    logic             is_sqrt;
    logic [StepW-1:0] steps;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

>>> hdl/rzs_ram.sv
module rzs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/rzs_unit.sv
module rzs_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rzs_pkg::unit_cmd_t         cmd_i,
  input  logic [rzs_pkg::OpW-1:0]    operand_i,
  input  logic [rzs_pkg::RemW-1:0]   divisor_i,
  output rzs_pkg::unit_sts_t         sts_o,
  output logic [rzs_pkg::OpW-1:0]    result_o
);
  import rzs_pkg::*;

  logic [OpW-1:0]   acc_q, res_q;
  logic [RemW-1:0]  rem_q, div_q, shifted, trial;
  logic [RemW:0]    diff;
  logic [StepW-1:0] cnt_q;
  logic             busy_q, done_q, sqrt_q, ge;

  // one restoring step: shift in one dividend bit or two radicand bits
  always_comb begin
    shifted = sqrt_q ? {rem_q[RemW-3:0], acc_q[OpW-1 -: 2]} : {rem_q[RemW-2:0], acc_q[OpW-1]};
    trial   = sqrt_q ? {res_q[RemW-3:0], 2'b01} : div_q;
    diff    = {1'b0, shifted} - {1'b0, trial};
    ge      = ~diff[RemW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == StepW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q  <= operand_i;
      div_q  <= divisor_i;
      rem_q  <= '0;
      res_q  <= '0;
      cnt_q  <= cmd_i.steps;
      sqrt_q <= cmd_i.is_sqrt;
    end else if (busy_q) begin
      acc_q <= sqrt_q ? {acc_q[OpW-3:0], 2'b00} : {acc_q[OpW-2:0], 1'b0};
      rem_q <= ge ? diff[RemW-1:0] : shifted;
      res_q <= {res_q[OpW-2:0], ge};
      cnt_q <= cnt_q - StepW'(1);
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign result_o   = res_q;

endmodule

>>> hdl/rolling_zscore_anomaly_detector.sv
// Rolling z-score anomaly detector.
// Input channel (in_valid_i / in_ready_o / in_data_i): a request is either a
// new signed Q8.8 sample or a clear of the window. Each request gives exactly
// one result on the output channel (out_valid_o / out_ready_i / out_data_o):
// z-score, validity, severity grade, window mean and stddev, fill level and
// the sample and event counters.
// A sample request goes through the window update (evict, add) and the
// multiplies, then the mean divide (24 steps), root of the spread (23), the
// stddev divide (24), the z divide (62) and the z root (31), all on one shared
// restoring divide / square root unit at one bit per cycle. The z steps are
// skipped when the z-score is invalid or the spread is zero. A clear skips
// all steps. One request is in work at a time; in_ready_o is high when idle.
// The output register holds a result until taken; while it is still full,
// a new result holds the block at its last step and no request is taken.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) are taken while
// idle and empty the window. Reset empties the window, clears the counters
// and loads window_length 64, min_count 2, soft_limit 512, hard_limit 768.
module rolling_zscore_anomaly_detector #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rzs_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rzs_pkg::out_res_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);
  import rzs_pkg::*;

  localparam int unsigned PW = $clog2(WINDOW_DEPTH);
  localparam int unsigned IW = PW + 8;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StEvict  = 4'd1;
  localparam logic [3:0] StAdd    = 4'd2;
  localparam logic [3:0] StMul    = 4'd3;
  localparam logic [3:0] StDiff   = 4'd4;
  localparam logic [3:0] StSqr    = 4'd5;
  localparam logic [3:0] StLaunch = 4'd6;
  localparam logic [3:0] StWait   = 4'd7;
  localparam logic [3:0] StOut    = 4'd8;

  localparam logic [2:0] OpMean  = 3'd0;
  localparam logic [2:0] OpRoot  = 3'd1;
  localparam logic [2:0] OpSd    = 3'd2;
  localparam logic [2:0] OpZdiv  = 3'd3;
  localparam logic [2:0] OpZroot = 3'd4;

  logic [3:0]             state_q;
  logic [2:0]             op_q;
  logic [6:0]             wl_q, mc_q, held_q, len;
  logic [15:0]            soft_q, hard_q;
  logic [PW-1:0]          wp_q, old_idx;
  logic [IW-1:0]          wp_ext, held_ext, idx_ext;
  logic signed [SumW-1:0] sum_q;
  logic [SqW-1:0]         sqs_q;
  logic [31:0]            smp_cnt_q, soft_cnt_q, hard_cnt_q;
  logic signed [15:0]     v_q, old_val;
  logic                   evict_q, clr_q, out_valid_q, zvalid;
  logic [47:0]            nq_q, ss_q;
  logic signed [24:0]     nv_q;
  logic [DevW-1:0]        d_q;
  logic signed [NumW-1:0] num_q;
  logic [DevW-1:0]        nn_q;
  logic [15:0]            mean_q, sd_q;
  logic [31:0]            mag_q;
  logic [SumW-1:0]        sum_abs;
  logic [NumW-1:0]        num_abs;
  logic [31:0]            v_sq, old_sq;
  logic [15:0]            rdata, z_val;
  logic [1:0]             sev;
  logic                   ram_we;
  out_res_t               out_q;
  unit_cmd_t              cmd;
  unit_sts_t              sts;
  logic [OpW-1:0]         operand, ures;
  logic [RemW-1:0]        divisor;

  // effective window length and the slot of the oldest held sample
  always_comb begin
    if (wl_q == 7'd0) begin
      len = 7'd1;
    end else if ({25'd0, wl_q} > WINDOW_DEPTH) begin
      len = 7'(WINDOW_DEPTH);
    end else begin
      len = wl_q;
    end
    wp_ext   = IW'(wp_q);
    held_ext = IW'(held_q);
    idx_ext  = (wp_ext >= held_ext) ? wp_ext - held_ext
                                    : wp_ext + IW'(WINDOW_DEPTH) - held_ext;
    old_idx  = idx_ext[PW-1:0];
  end

  assign ram_we = (state_q == StAdd);

  rzs_ram #(
    .WIDTH(16),
    .DEPTH(WINDOW_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(v_q),
    .raddr_i(old_idx),
    .rdata_o(rdata)
  );

  assign old_val = $signed(rdata);
  assign old_sq  = 32'($signed(old_val) * $signed(old_val));
  assign v_sq    = 32'($signed(v_q) * $signed(v_q));
  assign sum_abs = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign num_abs = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);
  assign zvalid  = (held_q >= mc_q);

  // operand selection for the shared unit
  always_comb begin
    cmd.start   = (state_q == StLaunch);
    cmd.is_sqrt = 1'b0;
    cmd.steps   = StepW'(24);
    operand     = {sum_abs, 40'd0};
    divisor     = RemW'(held_q);
    case (op_q)
      OpMean: begin
        operand = {sum_abs, 40'd0};
      end
      OpRoot: begin
        cmd.is_sqrt = 1'b1;
        cmd.steps   = StepW'(23);
        operand     = {d_q, 18'd0};
      end
      OpSd: begin
        operand = {ures[23:0], 40'd0};
      end
      OpZdiv: begin
        cmd.steps = StepW'(62);
        operand   = {nn_q, 18'd0};
        divisor   = RemW'(d_q);
      end
      OpZroot: begin
        cmd.is_sqrt = 1'b1;
        cmd.steps   = StepW'(31);
        operand     = {ures[61:0], 2'b00};
      end
      default: begin
        operand = {sum_abs, 40'd0};
      end
    endcase
  end

  rzs_unit u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .operand_i(operand),
    .divisor_i(divisor),
    .sts_o    (sts),
    .result_o (ures)
  );

  // saturated z-score and grade
  always_comb begin
    if (num_q[NumW-1]) begin
      z_val = (mag_q > 32'd32768) ? 16'h8000 : 16'(-mag_q);
    end else begin
      z_val = (mag_q > 32'd32767) ? 16'h7fff : mag_q[15:0];
    end
    if (mag_q >= {16'd0, hard_q}) begin
      sev = SevHard;
    end else if (mag_q >= {16'd0, soft_q}) begin
      sev = SevSoft;
    end else begin
      sev = SevNone;
    end
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OpMean;
      wl_q        <= 7'd64;
      mc_q        <= 7'd2;
      soft_q      <= 16'd512;
      hard_q      <= 16'd768;
      wp_q        <= '0;
      held_q      <= '0;
      sum_q       <= '0;
      sqs_q       <= '0;
      smp_cnt_q   <= '0;
      soft_cnt_q  <= '0;
      hard_cnt_q  <= '0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // output register valid flag
      if (state_q == StOut && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          // a config write or a clear request empties the window
          if ((cfg_we_i && cfg_idx_i <= RegHardLimit) ||
              (in_valid_i && in_data_i.req_type == ReqClear)) begin
            wp_q   <= '0;
            held_q <= '0;
            sum_q  <= '0;
            sqs_q  <= '0;
          end
          if (cfg_we_i && cfg_idx_i <= RegHardLimit) begin
            case (cfg_idx_i)
              RegWindowLength: wl_q   <= cfg_wdata_i[6:0];
              RegMinCount:     mc_q   <= cfg_wdata_i[6:0];
              RegSoftLimit:    soft_q <= cfg_wdata_i;
              default:         hard_q <= cfg_wdata_i;
            endcase
          end
          if (in_valid_i) begin
            if (in_data_i.req_type == ReqClear) begin
              clr_q   <= 1'b1;
              state_q <= StOut;
            end else begin
              smp_cnt_q <= smp_cnt_q + 32'd1;
              clr_q     <= 1'b0;
              state_q   <= StEvict;
            end
          end
        end
        StEvict: begin
          if (evict_q) begin
            sum_q  <= sum_q - SumW'(old_val);
            sqs_q  <= sqs_q - SqW'(old_sq);
            held_q <= held_q - 7'd1;
          end
          state_q <= StAdd;
        end
        StAdd: begin
          wp_q    <= (wp_q == PW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + PW'(1);
          held_q  <= held_q + 7'd1;
          sum_q   <= sum_q + SumW'(v_q);
          sqs_q   <= sqs_q + SqW'(v_sq);
          state_q <= StMul;
        end
        StMul:  state_q <= StDiff;
        StDiff: state_q <= StSqr;
        StSqr: begin
          op_q    <= OpMean;
          state_q <= StLaunch;
        end
        StLaunch: state_q <= StWait;
        StWait: begin
          if (sts.done) begin
            case (op_q)
              OpMean: begin
                op_q    <= OpRoot;
                state_q <= StLaunch;
              end
              OpRoot: begin
                op_q    <= OpSd;
                state_q <= StLaunch;
              end
              OpSd: begin
                if (zvalid && d_q != '0) begin
                  op_q    <= OpZdiv;
                  state_q <= StLaunch;
                end else begin
                  state_q <= StOut;
                end
              end
              OpZdiv: begin
                op_q    <= OpZroot;
                state_q <= StLaunch;
              end
              default: state_q <= StOut;
            endcase
          end
        end
        StOut: begin
          if (!out_valid_q || out_ready_i) begin
            if (!clr_q && zvalid) begin
              if (sev == SevHard) begin
                hard_cnt_q <= hard_cnt_q + 32'd1;
              end else if (sev == SevSoft) begin
                soft_cnt_q <= soft_cnt_q + 32'd1;
              end
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        v_q     <= in_data_i.sample_value;
        evict_q <= (held_q >= len);
        mag_q   <= '0;
      end
      StMul: begin
        nq_q <= 48'(held_q * sqs_q);
        ss_q <= 48'(sum_abs * sum_abs);
        nv_q <= 25'($signed({1'b0, held_q}) * v_q);
      end
      StDiff: begin
        d_q   <= (nq_q > ss_q) ? DevW'(nq_q - ss_q) : '0;
        num_q <= NumW'(nv_q - 25'(sum_q));
      end
      StSqr: begin
        nn_q <= DevW'(num_abs * num_abs);
      end
      StWait: begin
        if (sts.done) begin
          case (op_q)
            OpMean: mean_q <= sum_q[SumW-1] ? 16'(-ures) : ures[15:0];
            OpSd: begin
              if (held_q < 7'd2) begin
                sd_q <= '0;
              end else begin
                sd_q <= (ures[63:16] != '0) ? 16'hffff : ures[15:0];
              end
            end
            OpZroot: mag_q <= ures[31:0];
            default: mag_q <= mag_q;
          endcase
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.fill_level    <= held_q;
          out_q.total_samples <= smp_cnt_q;
          if (clr_q) begin
            out_q.z_score       <= '0;
            out_q.z_valid       <= 1'b0;
            out_q.severity      <= SevNone;
            out_q.window_mean   <= '0;
            out_q.window_stddev <= '0;
            out_q.soft_events   <= soft_cnt_q;
            out_q.hard_events   <= hard_cnt_q;
          end else begin
            out_q.z_score       <= zvalid ? z_val : '0;
            out_q.z_valid       <= zvalid;
            out_q.severity      <= zvalid ? sev : SevNone;
            out_q.window_mean   <= mean_q;
            out_q.window_stddev <= sd_q;
            out_q.soft_events   <= soft_cnt_q + 32'((zvalid && sev == SevSoft) ? 1 : 0);
            out_q.hard_events   <= hard_cnt_q + 32'((zvalid && sev == SevHard) ? 1 : 0);
          end
        end
      end
      default: mag_q <= mag_q;
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> tb/rolling_zscore_anomaly_detector_checker.sv
`timescale 1ns / 1ps

module rolling_zscore_anomaly_detector_checker
  import rzs_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_req_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_res_t    out_data_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // shadow configuration
  logic [6:0]  win_len;
  logic [6:0]  min_cnt;
  logic [15:0] soft_lim;
  logic [15:0] hard_lim;

  // shadow window state
  logic signed [15:0] ring [WINDOW_DEPTH];
  int unsigned        wr_ptr;
  int unsigned        held;
  longint             win_sum;
  longint unsigned    win_sq_sum;
  logic [31:0]        sample_cnt;
  logic [31:0]        soft_cnt;
  logic [31:0]        hard_cnt;

  out_res_t    expected_results[$];
  int unsigned mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_results.size();

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic clear_window();
    wr_ptr     = 0;
    held       = 0;
    win_sum    = 0;
    win_sq_sum = 0;
  endtask

  // score one request and update the shadow state
  task automatic score_request(input in_req_t req, output out_res_t res);
    longint          s, n, num, oldest, len;
    longint unsigned abs_sum, dev, nn, quo, rem, mag, sd;
    res = '0;
    if (req.req_type == ReqClear) begin
      clear_window();
    end else begin
      s = longint'(req.sample_value);
      len = (win_len == 0) ? 1 : (win_len > WINDOW_DEPTH ? WINDOW_DEPTH : win_len);
      sample_cnt += 1;
      if (held >= len) begin
        oldest = ring[(wr_ptr + WINDOW_DEPTH - (held % WINDOW_DEPTH)) % WINDOW_DEPTH];
        win_sum -= oldest;
        win_sq_sum -= longint'(oldest * oldest);
        held -= 1;
      end
      ring[wr_ptr % WINDOW_DEPTH] = 16'(s);
      wr_ptr = (wr_ptr + 1) % WINDOW_DEPTH;
      held += 1;
      win_sum += s;
      win_sq_sum += longint'(s * s);
      n = held;
      abs_sum = (win_sum < 0) ? -win_sum : win_sum;
      dev = (n * win_sq_sum > abs_sum * abs_sum) ? n * win_sq_sum - abs_sum * abs_sum : 0;
      res.window_mean = 16'(win_sum / n);
      if (n >= 2) begin
        sd = int_sqrt(dev) / n;
        res.window_stddev = (sd > 16'hFFFF) ? 16'hFFFF : 16'(sd);
      end
      if (n >= min_cnt) begin
        num = n * s - win_sum;
        mag = 0;
        res.z_valid = 1'b1;
        if (dev != 0) begin
          nn  = (num < 0) ? -num : num;
          nn  = nn * nn;
          quo = nn / dev;
          rem = nn % dev;
          for (int i = 0; i < 16; i++) begin
            rem <<= 1;
            quo <<= 1;
            if (rem >= dev) begin
              rem -= dev;
              quo |= 1;
            end
          end
          mag = int_sqrt(quo);
        end
        if (num < 0) res.z_score = (mag > 32768) ? 16'sh8000 : 16'(-longint'(mag));
        else         res.z_score = (mag > 32767) ? 16'sh7FFF : 16'(mag);
        if (mag >= hard_lim) begin
          res.severity = SevHard;
          hard_cnt += 1;
        end else if (mag >= soft_lim) begin
          res.severity = SevSoft;
          soft_cnt += 1;
        end
      end
    end
    res.fill_level    = 7'(held);
    res.total_samples = sample_cnt;
    res.soft_events   = soft_cnt;
    res.hard_events   = hard_cnt;
  endtask

  // watch the three ports at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_res_t want;
    if (!rst_ni) begin
      win_len    = 7'd64;
      min_cnt    = 7'd2;
      soft_lim   = 16'd512;
      hard_lim   = 16'd768;
      sample_cnt = 0;
      soft_cnt   = 0;
      hard_cnt   = 0;
      mismatches = 0;
      clear_window();
      expected_results.delete();
    end else begin
      // config write
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegWindowLength: begin win_len = cfg_wdata_i[6:0]; clear_window(); end
          RegMinCount:     begin min_cnt = cfg_wdata_i[6:0]; clear_window(); end
          RegSoftLimit:    begin soft_lim = cfg_wdata_i; clear_window(); end
          RegHardLimit:    begin hard_lim = cfg_wdata_i; clear_window(); end
          default: ;
        endcase
      end
      // result check
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data_i);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (want !== out_data_i) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data_i);
          end
        end
      end
      // accepted request
      if (in_valid_i && in_ready_i) begin
        score_request(in_data_i, want);
        expected_results.insert(expected_results.size(), want);
      end
    end
  end

endmodule

>>> tb/rolling_zscore_anomaly_detector_tb.sv
`timescale 1ns / 1ps

module rolling_zscore_anomaly_detector_tb;
  import rzs_pkg::*;

  localparam int unsigned CycleLimit = 900000;
  localparam logic [2:0]  RegUnused  = 3'd5;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_req_t     in_data;
  logic        out_valid;
  logic        out_ready;
  out_res_t    out_data;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_wdata;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count = 0;

  rolling_zscore_anomaly_detector u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  rolling_zscore_anomaly_detector_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays high into the next request when the sender does not idle
  task automatic send_request(input logic kind, input logic [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: kind, sample_value: value};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // drain and then write one register
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // a run of samples, mostly clustered around a level with occasional spikes, and now and then a clear
  task automatic sample_burst(input int unsigned count);
    logic [15:0] level;
    logic [15:0] value;
    level = 16'($urandom);
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: value = 16'($urandom);
        1: value = level;
        2: value = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
        default: value = level + 16'($signed($urandom_range(512)) - 256);
      endcase
      if ($urandom_range(39) == 0) send_request(ReqClear, 16'($urandom));
      else                         send_request(ReqSample, value);
    end
  endtask

  initial begin
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = RegWindowLength;
    cfg_wdata     = '0;
    send_idle_pct = 31;
    recv_idle_pct = 50;
    rst_ni        = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, flat window, clear
    send_request(ReqSample, 16'h8000);
    send_request(ReqSample, 16'h7FFF);
    send_request(ReqSample, 16'h8000);
    send_request(ReqSample, 16'h0000);
    send_request(ReqClear,  16'hFFFF);
    repeat (4) send_request(ReqSample, 16'h0100);
    send_request(ReqSample, 16'h7FFF);
    send_request(ReqSample, 16'hFFFF);

    // min count of zero, window of one
    write_reg(RegMinCount, 16'd0);
    write_reg(RegWindowLength, 16'd0);
    send_request(ReqSample, 16'h1234);
    send_request(ReqSample, 16'h8000);
    write_reg(RegWindowLength, 16'd1);
    send_request(ReqSample, 16'h5555);
    // window length above depth, min count above length, zero soft limit and full-scale hard limit
    write_reg(RegWindowLength, 16'hFFFF);
    write_reg(RegMinCount, 16'd127);
    send_request(ReqSample, 16'hAAAA);
    send_request(ReqSample, 16'h0001);
    write_reg(RegMinCount, 16'd1);
    write_reg(RegSoftLimit, 16'd0);
    write_reg(RegHardLimit, 16'hFFFF);
    send_request(ReqSample, 16'h0010);
    send_request(ReqSample, 16'h7000);
    write_reg(RegUnused, 16'd7);
    send_request(ReqSample, 16'h9000);

    // random phases over several settings and idle profiles
    for (int unsigned phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin send_idle_pct = 50; recv_idle_pct = 31; end
      if (phase == 6) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      case (phase % 3)
        0: begin
          write_reg(RegWindowLength, 16'($urandom_range(2, 8)));
          write_reg(RegMinCount, 16'($urandom_range(1, 4)));
        end
        1: begin
          write_reg(RegWindowLength, 16'd64);
          write_reg(RegMinCount, 16'd2);
        end
        default: begin
          write_reg(RegWindowLength, 16'($urandom_range(0, 127)));
          write_reg(RegMinCount, 16'($urandom_range(0, 70)));
        end
      endcase
      write_reg(RegSoftLimit, 16'($urandom_range(64, 700)));
      write_reg(RegHardLimit, 16'($urandom_range(300, 1200)));
      sample_burst(55);
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
